>>> design/multi_voice_pcm_mixer_assert.svh
// Assertion macros used by the mixer's command engine.
`ifndef MULTI_VOICE_PCM_MIXER_ASSERT_SVH
`define MULTI_VOICE_PCM_MIXER_ASSERT_SVH
`ifndef SYNTHESIS
`define MVM_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MVM_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define MVM_ASSERT_CLK(label, clk, rst, prop, msg)
`define MVM_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

>>> design/mvm_pkg.sv
// Types and constants of the multi-voice PCM mixer.
`default_nettype none
package mvm_pkg;
   localparam int VOICE_COUNT  = 8;
   localparam int VIDX_W       = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int SAMPLE_DEPTH = 65536;
   localparam int SAMPLE_AW    = $clog2(SAMPLE_DEPTH);
   localparam int QDEPTH       = 2;
   localparam int QPTR_W       = 1;
   localparam int DIV_NW       = 34;
   localparam int DIV_DW       = 18;
   localparam int DIV_CW       = 6;

   localparam logic [17:0] FRAME_RATE_RESET = 18'd22050;
   localparam logic [8:0]  GAIN_MAX         = 9'd256;
   localparam logic [14:0] GEN_MAX          = 15'h7fff;
   localparam logic [14:0] GEN_FIRST        = 15'd1;

   localparam logic [2:0] CMD_LOAD     = 3'd0;
   localparam logic [2:0] CMD_START    = 3'd1;
   localparam logic [2:0] CMD_STOP     = 3'd2;
   localparam logic [2:0] CMD_VOLUME   = 3'd3;
   localparam logic [2:0] CMD_QUERY    = 3'd4;
   localparam logic [2:0] CMD_STOP_ALL = 3'd5;
   localparam logic [2:0] CMD_RENDER   = 3'd6;
   localparam logic [2:0] CMD_CLEAR    = 3'd7;

   typedef enum logic [2:0] {
      OP_LOAD, OP_START, OP_STOP, OP_VOLUME, OP_QUERY, OP_STOP_ALL, OP_RENDER, OP_CLEAR
   } op_type;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [30:0]        voice_handle;
      logic [15:0]        load_address;
      logic signed [15:0] load_data;
      logic [15:0]        sound_base;
      logic [16:0]        sound_length;
      logic [17:0]        source_rate;
      logic [15:0]        volume_level;
      logic               loop_flag;
   } req_type;

   typedef struct packed {
      logic [30:0]        result_handle;
      logic               playing_flag;
      logic signed [15:0] mix_sample;
   } rsp_type;

   typedef struct packed {
      op_type  op;
      req_type req;
   } entry_type;

   function automatic logic [8:0] clamp_gain(input logic [15:0] level);
      if (level > 16'(GAIN_MAX)) begin
         return GAIN_MAX;
      end
      return level[8:0];
   endfunction
endpackage
`default_nettype wire

>>> design/mvm_front.sv
// Request front end: command decode and a short request queue.
`default_nettype none
module mvm_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_push,
   input  mvm_pkg::req_type      req_data,
   output logic                  req_full,
   input  wire                   q_pop,
   output mvm_pkg::entry_type    q_head,
   output logic                  q_empty
);
   import mvm_pkg::*;

   entry_type         slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wptr_ff, rptr_ff;
   logic [QPTR_W:0]   count_ff;
   op_type            op;
   logic              do_push, do_pop;

   always_comb begin
      unique case (req_data.cmd)
         CMD_LOAD:     op = OP_LOAD;
         CMD_START:    op = OP_START;
         CMD_STOP:     op = OP_STOP;
         CMD_VOLUME:   op = OP_VOLUME;
         CMD_QUERY:    op = OP_QUERY;
         CMD_STOP_ALL: op = OP_STOP_ALL;
         CMD_RENDER:   op = OP_RENDER;
         default:      op = OP_CLEAR;
      endcase
   end

   assign req_full = (count_ff == (QPTR_W+1)'(QDEPTH));
   assign q_empty  = (count_ff == '0);
   assign do_push  = req_push && !req_full;
   assign do_pop   = q_pop && !q_empty;
   assign q_head   = slot_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= '{op: op, req: req_data};
      end
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) wptr_ff <= wptr_ff + 1'b1;
         if (do_pop)  rptr_ff <= rptr_ff + 1'b1;
         if (do_push && !do_pop) count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end
endmodule
`default_nettype wire

>>> design/mvm_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module mvm_div (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire [mvm_pkg::DIV_NW-1:0]    dividend,
   input  wire [mvm_pkg::DIV_DW-1:0]    divisor,
   output logic                         busy,
   output logic                         done,
   output logic [mvm_pkg::DIV_NW-1:0]   quotient,
   output logic [mvm_pkg::DIV_DW-1:0]   remainder
);
   import mvm_pkg::*;

   logic [DIV_NW-1:0] quo_ff;
   logic [DIV_DW-1:0] rem_ff, dvs_ff;
   logic [DIV_CW-1:0] cnt_ff;
   logic              busy_ff, done_ff;
   logic [DIV_DW:0]   shifted;
   logic [DIV_DW+1:0] diff;
   logic              ge;

   assign shifted   = {rem_ff, quo_ff[DIV_NW-1]};
   assign diff      = {1'b0, shifted} - {2'b00, dvs_ff};
   assign ge        = !diff[DIV_DW+1];
   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quo_ff  <= dividend;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
            cnt_ff  <= DIV_CW'(DIV_NW);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= ge ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
            quo_ff <= {quo_ff[DIV_NW-2:0], ge};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
endmodule
`default_nettype wire

>>> design/mvm_back.sv
// Command engine: voice table, sample memory, render walk and result register.
`default_nettype none
`include "multi_voice_pcm_mixer_assert.svh"
module mvm_back (
   input  wire                    clock,
   input  wire                    reset,
   input  mvm_pkg::entry_type     q_head,
   input  wire                    q_empty,
   output logic                   q_pop,
   input  wire                    csr_valid,
   input  wire  [17:0]            csr_data,
   output mvm_pkg::rsp_type       rsp_data,
   output logic                   rsp_empty,
   input  wire                    rsp_pop
);
   import mvm_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_ST_DIV, S_HANDLE, S_RV_CHECK, S_RV_MOD, S_RV_READ, S_RV_MUL, S_RV_ACC, S_RESP
   } state_type;

   state_type          state_ff;
   entry_type          cur_ff;
   rsp_type            res_ff, rsp_ff;
   logic               rsp_valid_ff;
   logic [17:0]        frame_rate_ff;
   logic [VIDX_W-1:0]  vidx_ff;
   logic               hit_ff;
   logic [14:0]        next_gen_ff;
   logic signed [15:0] mix_ff;
   logic signed [25:0] prod_ff;
   logic signed [15:0] rd_data_ff;
   logic               in_range_ff;

   logic [15:0]            base_ff [VOICE_COUNT];
   logic [16:0]            len_ff  [VOICE_COUNT];
   logic [31:0]            pos_ff  [VOICE_COUNT];
   logic [15:0]            frac_ff [VOICE_COUNT];
   logic [15:0]            stw_ff  [VOICE_COUNT];
   logic [15:0]            stf_ff  [VOICE_COUNT];
   logic [8:0]             gain_ff [VOICE_COUNT];
   logic [14:0]            gen_ff  [VOICE_COUNT];
   logic [VOICE_COUNT-1:0] loop_ff, act_ff;

   logic signed [15:0] mem [SAMPLE_DEPTH];

   logic                 free_any;
   logic [VIDX_W-1:0]    free_idx;
   logic [15:0]          hlow;
   logic                 hit_in;
   logic [VIDX_W-1:0]    hidx;
   logic                 div_start, div_busy, div_done;
   logic [DIV_NW-1:0]    div_dividend, div_quo;
   logic [DIV_DW-1:0]    div_divisor, div_rem;
   logic [31:0]          step;
   logic [15:0]          rd_addr;
   logic                 rd_in_range;
   logic                 mem_we;
   logic                 wr_in_range;
   logic                 last_voice;
   logic                 match;
   logic signed [17:0]   sum;
   logic signed [15:0]   sum_sat;
   logic [16:0]          frac_sum;
   logic signed [15:0]   sample;
   logic signed [9:0]    gain_s;
   logic                 out_free;
   logic [14:0]          gen_inc;

   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
         if (!act_ff[i]) begin
            free_any = 1'b1;
            free_idx = VIDX_W'(i);
         end
      end
   end

   assign hlow   = q_head.req.voice_handle[15:0];
   assign hit_in = (hlow != '0) && (hlow <= 16'(VOICE_COUNT));
   assign hidx   = VIDX_W'(hlow - 16'd1);
   assign match  = hit_ff && (gen_ff[vidx_ff] == cur_ff.req.voice_handle[30:16]);

   assign step = (div_quo[DIV_NW-1:32] != '0) ? 32'hffff_ffff : div_quo[31:0];

   assign rd_addr     = base_ff[vidx_ff] + pos_ff[vidx_ff][15:0];
   assign rd_in_range = {1'b0, rd_addr} < 17'(SAMPLE_DEPTH);
   assign wr_in_range = {1'b0, q_head.req.load_address} < 17'(SAMPLE_DEPTH);
   assign q_pop  = (state_ff == S_IDLE) && !q_empty;
   assign mem_we = q_pop && (q_head.op == OP_LOAD) && wr_in_range;

   assign last_voice = (vidx_ff == VIDX_W'(VOICE_COUNT - 1));
   assign sample     = in_range_ff ? rd_data_ff : 16'sd0;
   assign gain_s     = $signed({1'b0, gain_ff[vidx_ff]});
   assign sum        = $signed({{2{mix_ff[15]}}, mix_ff}) + $signed(prod_ff[25:8]);
   assign sum_sat    = (sum > 18'sd32767) ? 16'sh7fff :
                       (sum < -18'sd32768) ? 16'sh8000 : sum[15:0];
   assign frac_sum   = {1'b0, frac_ff[vidx_ff]} + {1'b0, stf_ff[vidx_ff]};
   assign gen_inc    = (next_gen_ff == GEN_MAX) ? GEN_FIRST : next_gen_ff + 15'd1;
   assign out_free   = !rsp_valid_ff || rsp_pop;

   always_comb begin
      div_start    = 1'b0;
      div_dividend = {q_head.req.source_rate, 16'd0};
      div_divisor  = frame_rate_ff;
      if (q_pop && (q_head.op == OP_START) && (q_head.req.sound_length != '0) &&
          (frame_rate_ff != '0) && free_any) begin
         div_start = 1'b1;
      end
      if (state_ff == S_RV_CHECK) begin
         div_dividend = {2'b00, pos_ff[vidx_ff]};
         div_divisor  = {1'b0, len_ff[vidx_ff]};
         if (act_ff[vidx_ff] && (pos_ff[vidx_ff] >= 32'(len_ff[vidx_ff])) &&
             loop_ff[vidx_ff] && (len_ff[vidx_ff] != '0)) begin
            div_start = 1'b1;
         end
      end
   end

   mvm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[q_head.req.load_address[SAMPLE_AW-1:0]] <= q_head.req.load_data;
      end
      rd_data_ff <= mem[rd_addr[SAMPLE_AW-1:0]];
   end

   assign rsp_data  = rsp_ff;
   assign rsp_empty = !rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         frame_rate_ff <= FRAME_RATE_RESET;
         next_gen_ff   <= GEN_FIRST;
         act_ff        <= '0;
         loop_ff       <= '0;
         vidx_ff       <= '0;
         for (int i = 0; i < VOICE_COUNT; i++) begin
            base_ff[i] <= '0;
            len_ff[i]  <= '0;
            pos_ff[i]  <= '0;
            frac_ff[i] <= '0;
            stw_ff[i]  <= '0;
            stf_ff[i]  <= '0;
            gain_ff[i] <= '0;
            gen_ff[i]  <= '0;
         end
      end else begin
         if (csr_valid) frame_rate_ff <= csr_data;
         // load a finished result, else drop the one just taken
         if ((state_ff == S_RESP) && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_pop) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (q_pop) begin
                  cur_ff   <= q_head;
                  res_ff   <= '0;
                  state_ff <= S_RESP;
                  unique case (q_head.op)
                     OP_START: begin
                        vidx_ff <= free_idx;
                        if (div_start) state_ff <= S_ST_DIV;
                     end
                     OP_STOP, OP_VOLUME, OP_QUERY: begin
                        vidx_ff  <= hidx;
                        hit_ff   <= hit_in;
                        state_ff <= S_HANDLE;
                     end
                     OP_STOP_ALL: act_ff <= '0;
                     OP_RENDER: begin
                        vidx_ff  <= '0;
                        mix_ff   <= '0;
                        state_ff <= S_RV_CHECK;
                     end
                     OP_CLEAR: begin
                        next_gen_ff <= GEN_FIRST;
                        act_ff      <= '0;
                        loop_ff     <= '0;
                        for (int i = 0; i < VOICE_COUNT; i++) begin
                           base_ff[i] <= '0;
                           len_ff[i]  <= '0;
                           pos_ff[i]  <= '0;
                           frac_ff[i] <= '0;
                           stw_ff[i]  <= '0;
                           stf_ff[i]  <= '0;
                           gain_ff[i] <= '0;
                           gen_ff[i]  <= '0;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_ST_DIV: begin
               if (div_done) begin
                  base_ff[vidx_ff] <= cur_ff.req.sound_base;
                  len_ff[vidx_ff]  <= cur_ff.req.sound_length;
                  pos_ff[vidx_ff]  <= '0;
                  frac_ff[vidx_ff] <= '0;
                  stw_ff[vidx_ff]  <= step[31:16];
                  stf_ff[vidx_ff]  <= step[15:0];
                  gain_ff[vidx_ff] <= clamp_gain(cur_ff.req.volume_level);
                  loop_ff[vidx_ff] <= cur_ff.req.loop_flag;
                  act_ff[vidx_ff]  <= 1'b1;
                  gen_ff[vidx_ff]  <= next_gen_ff;
                  next_gen_ff      <= gen_inc;
                  res_ff.result_handle <= {next_gen_ff, 16'(vidx_ff) + 16'd1};
                  state_ff <= S_RESP;
               end
            end
            S_HANDLE: begin
               priority case (cur_ff.op)
                  OP_STOP:   if (match) act_ff[vidx_ff] <= 1'b0;
                  OP_VOLUME: if (match) gain_ff[vidx_ff] <= clamp_gain(cur_ff.req.volume_level);
                  default:   res_ff.playing_flag <= match && act_ff[vidx_ff];
               endcase
               state_ff <= S_RESP;
            end
            S_RV_CHECK: begin
               if (div_start) begin
                  state_ff <= S_RV_MOD;
               end else if (act_ff[vidx_ff] && (pos_ff[vidx_ff] < 32'(len_ff[vidx_ff]))) begin
                  state_ff <= S_RV_READ;
               end else begin
                  // drop an ended one-shot voice, skip an idle one
                  act_ff[vidx_ff] <= 1'b0;
                  if (last_voice) begin
                     res_ff.mix_sample <= mix_ff;
                     state_ff <= S_RESP;
                  end else begin
                     vidx_ff <= vidx_ff + 1'b1;
                  end
               end
            end
            S_RV_MOD: begin
               if (div_done) begin
                  pos_ff[vidx_ff] <= {15'd0, div_rem[16:0]};
                  state_ff <= S_RV_READ;
               end
            end
            S_RV_READ: begin
               in_range_ff <= rd_in_range;
               state_ff    <= S_RV_MUL;
            end
            S_RV_MUL: begin
               prod_ff  <= sample * gain_s;
               state_ff <= S_RV_ACC;
            end
            S_RV_ACC: begin
               frac_ff[vidx_ff] <= frac_sum[15:0];
               pos_ff[vidx_ff]  <= pos_ff[vidx_ff] + {16'd0, stw_ff[vidx_ff]} +
                                   32'(frac_sum[16]);
               mix_ff <= sum_sat;
               if (last_voice) begin
                  res_ff.mix_sample <= sum_sat;
                  state_ff <= S_RESP;
               end else begin
                  vidx_ff  <= vidx_ff + 1'b1;
                  state_ff <= S_RV_CHECK;
               end
            end
            S_RESP: begin
               // hold the result until the output register frees up
               if (out_free) begin
                  rsp_ff   <= res_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `MVM_ASSERT_NEVER(a_gen_zero, clock, reset, next_gen_ff == '0, "next generation is zero")
   `MVM_ASSERT_CLK(a_div_idle, clock, reset, div_start |-> !div_busy, "divider restarted")
   `MVM_ASSERT_CLK(a_start_free, clock, reset, (state_ff == S_ST_DIV && div_done) |-> !act_ff[vidx_ff], "start hit an active voice")
endmodule
`default_nettype wire

>>> design/multi_voice_pcm_mixer.sv
// Top level of the multi-voice PCM mixer.
// Usage:
//   Requests enter through req_push/req_full as one req_type word; each
//   request yields exactly one result word on rsp_data, shown while
//   rsp_empty is low and taken with rsp_pop.
//   csr_valid/csr_ready writes the output frame rate; write it only while
//   no request is in flight. csr_ready is always high.
// Path from request accept to result shown, one request at a time:
//   load, stop all, clear, failed start: straight to the result state;
//   stop, volume, query: handle check; start: the 34-step rate divider;
//   render: per voice a check, then read, scale and sum if playing, plus
//   a modulo on the divider for each looping voice that wraps.
// Throughput: the engine works on one request at a time and pops the next
//   one the cycle after it hands a result to the output register.
// A two-entry request queue lets the sender run ahead of the engine.
// Reset clears the voices, empties the queue and the result register, sets the rate
// to 22050 Hz; sample memory is not cleared and must be loaded before use.
// When the receiver stalls, the engine holds a finished result and then
// stops taking requests; the queue fills and req_full goes high.
`default_nettype none
module multi_voice_pcm_mixer (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_push,
   output logic                req_full,
   input  mvm_pkg::req_type    req_data,
   output logic                rsp_empty,
   input  wire                 rsp_pop,
   output mvm_pkg::rsp_type    rsp_data,
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire  [17:0]         csr_data
);
   import mvm_pkg::*;

   entry_type q_head;
   logic      q_empty, q_pop;

   assign csr_ready = 1'b1;

   mvm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_pop    (q_pop),
      .q_head   (q_head),
      .q_empty  (q_empty)
   );

   mvm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );
endmodule
`default_nettype wire
